// ----- hdl/assert_macros.svh -----
// Assertion helpers included by the detector unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/btn_dbnc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Button debounce package
// Types and constants of the button debounce and hold detector.
// ----------------------------------------------------------------------------
package btn_dbnc_pkg;

   localparam int NUM_BUTTONS = 5;
   localparam int BTN_AW      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int RAW_EXT_W   = 1 << BTN_AW;
   localparam int CSR_IDX_W   = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD     = CSR_IDX_W'(1);

   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [15:0] HOLD_RESET     = 16'd500;

   localparam logic FUNC_POLL = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_PRESSED  = 2'd1,
      EV_RELEASED = 2'd2,
      EV_HELD     = 2'd3
   } event_type;

   typedef struct packed {
      logic        func;
      logic [4:0]  raw_levels;
      logic [31:0] now_ms;
      logic [2:0]  button_sel;
   } req_type;

   typedef struct packed {
      logic [2:0] button;
      event_type  event_res;
      logic       pressed;
      logic       last;
   } rsp_type;

   // One memory word per button.
   typedef struct packed {
      logic        raw_seen;
      logic [31:0] change_stamp;
      logic        debounced_level;
      logic [31:0] press_stamp;
      logic        hold_done;
      event_type   pending_event;
   } entry_type;

   // One button's worth of work moving from issue to update.
   typedef struct packed {
      logic              func;
      logic              raw_bit;
      logic [31:0]       now_ms;
      logic [BTN_AW-1:0] addr;
      logic [2:0]        button;
      logic              in_range;
      logic              last;
   } tok_type;

endpackage
`default_nettype wire

// ----- hdl/button_debounce_hold_detector_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Button debounce and hold detector
// Debounces five button levels and reports press, release and hold events.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer. A poll (func 0) brings the raw levels
//   and a millisecond time stamp; a read (func 1) fetches and clears the
//   pending event of button button_sel. rsp_* returns results; the last result
//   of an item has last set. A poll with no event gives one result with
//   button 0, event none. csr_* writes debounce_ms (index 0) and hold_ms
//   (index 1); csr_ready is always high.
//   Rate: one button state word is read, updated and written back per cycle
//   while nothing stalls, through a read port and a write port of the state
//   memory; a read handles one word. Items follow each other without gaps.
//   A read result passes the update, holding and output registers in turn.
//   A poll event result leaves once the next event or the end of the poll is
//   known, since only then its last flag is settled.
//   Reset clears the configuration to 50 ms and 500 ms; per-button valid bits
//   make all state words read as zero, no clearing pass is needed.
//   When rsp_ready is low the output register holds, the result in the
//   holding stage waits, and then the update stage and issue stall; req_ready
//   drops once the item register cannot drain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_debounce_hold_detector_unit
   import btn_dbnc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,

   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_data
);

   // ---------------------------------------------------------------- config
   logic [15:0] debounce_ff;
   logic [15:0] hold_ff;
   logic [15:0] hold_lim;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         hold_ff     <= HOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_data;
            CSR_HOLD:     hold_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // A hold time of zero acts as one, so a hold fires on a later poll.
   assign hold_lim = (hold_ff == 16'd0) ? 16'd1 : hold_ff;

   // ---------------------------------------------------------- issue stage
   // The item register walks the buttons of a poll, one per cycle while the update stage is free.
   logic              item_valid_ff;
   req_type           item_ff;
   logic [BTN_AW-1:0] idx_ff;
   logic              req_take;
   logic              issue;
   logic              tok_last;
   logic              sel_in_range;
   logic [RAW_EXT_W-1:0] raw_ext;
   tok_type           tok_in;

   logic    s1_valid_ff;
   tok_type s1_tok_ff;
   logic    s1_adv;
   logic    s1_free;

   assign sel_in_range = {1'b0, item_ff.button_sel} < 4'(NUM_BUTTONS);
   assign tok_last     = (item_ff.func == FUNC_READ) ||
                         (idx_ff == BTN_AW'(NUM_BUTTONS - 1));
   assign s1_free      = !s1_valid_ff || s1_adv;
   assign issue        = item_valid_ff && s1_free;
   assign req_ready    = !item_valid_ff || (issue && tok_last);
   assign req_take     = req_valid && req_ready;
   assign raw_ext      = RAW_EXT_W'(item_ff.raw_levels);

   always_comb begin
      tok_in          = '0;
      tok_in.func     = item_ff.func;
      tok_in.now_ms   = item_ff.now_ms;
      tok_in.last     = tok_last;
      if (item_ff.func == FUNC_READ) begin
         tok_in.raw_bit  = 1'b0;
         tok_in.button   = item_ff.button_sel;
         tok_in.in_range = sel_in_range;
         tok_in.addr     = sel_in_range ? item_ff.button_sel[BTN_AW-1:0] : '0;
      end else begin
         tok_in.raw_bit  = raw_ext[idx_ff];
         tok_in.button   = 3'(idx_ff);
         tok_in.in_range = 1'b1;
         tok_in.addr     = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else if (req_take) begin
         item_valid_ff <= 1'b1;
         idx_ff        <= '0;
      end else if (issue && tok_last) begin
         item_valid_ff <= 1'b0;
      end else if (issue) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (issue) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_tok_ff <= tok_in;
      end
   end

   // --------------------------------------------------------- state memory
   // While the update stage stalls, re-read its own word so the read data
   // stays current.
   entry_type         mem [NUM_BUTTONS];
   entry_type         mem_q_ff;
   logic [BTN_AW-1:0] rd_addr;
   logic              mem_we;
   entry_type         entry_in;
   logic [NUM_BUTTONS-1:0] ent_valid_ff;
   logic              fwd_valid_ff;
   logic [BTN_AW-1:0] fwd_addr_ff;
   entry_type         fwd_data_ff;

   assign rd_addr = issue ? tok_in.addr : s1_tok_ff.addr;

   always_ff @(posedge clock) begin
      mem_q_ff <= mem[rd_addr];
      if (mem_we) begin
         mem[s1_tok_ff.addr] <= entry_in;
      end
   end

   // Valid bits stand in for clearing the memory at reset; the forward
   // register covers a write that the read just before it missed.
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (mem_we) begin
         ent_valid_ff[s1_tok_ff.addr] <= 1'b1;
         fwd_valid_ff                 <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         fwd_addr_ff <= s1_tok_ff.addr;
         fwd_data_ff <= entry_in;
      end
   end

   // ---------------------------------------------------------- update stage
   entry_type   cur;
   entry_type   poll_entry;
   entry_type   read_entry;
   logic        raw_chg;
   logic [31:0] stamp_n;
   logic [31:0] since_change;
   logic [31:0] since_press;
   logic        accept_lvl;
   logic        new_press;
   logic        deb_n;
   logic [31:0] press_n;
   logic        hold_n;
   logic        hold_hit;
   event_type   poll_ev;
   logic        has_res;
   rsp_type     res;

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_tok_ff.addr)) begin
         cur = fwd_data_ff;
      end else if (ent_valid_ff[s1_tok_ff.addr]) begin
         cur = mem_q_ff;
      end else begin
         cur = '0;
      end
   end

   // Poll update of one button: track the raw level, accept it once it has
   // been stable long enough, then watch for the hold time.
   assign raw_chg      = s1_tok_ff.raw_bit != cur.raw_seen;
   assign stamp_n      = raw_chg ? s1_tok_ff.now_ms : cur.change_stamp;
   assign since_change = s1_tok_ff.now_ms - stamp_n;
   assign accept_lvl   = (since_change >= {16'd0, debounce_ff}) &&
                         (s1_tok_ff.raw_bit != cur.debounced_level);
   assign new_press    = accept_lvl && s1_tok_ff.raw_bit;
   assign deb_n        = accept_lvl ? s1_tok_ff.raw_bit : cur.debounced_level;
   assign press_n      = new_press ? s1_tok_ff.now_ms : cur.press_stamp;
   assign hold_n       = new_press ? 1'b0 : cur.hold_done;
   assign since_press  = s1_tok_ff.now_ms - press_n;
   assign hold_hit     = !accept_lvl && deb_n && !hold_n &&
                         (since_press >= {16'd0, hold_lim});

   always_comb begin
      if (accept_lvl) begin
         poll_ev = s1_tok_ff.raw_bit ? EV_PRESSED : EV_RELEASED;
      end else if (hold_hit) begin
         poll_ev = EV_HELD;
      end else begin
         poll_ev = EV_NONE;
      end
   end

   always_comb begin
      poll_entry.raw_seen        = s1_tok_ff.raw_bit;
      poll_entry.change_stamp    = stamp_n;
      poll_entry.debounced_level = deb_n;
      poll_entry.press_stamp     = press_n;
      poll_entry.hold_done       = hold_n || hold_hit;
      poll_entry.pending_event   = (poll_ev != EV_NONE) ? poll_ev : cur.pending_event;
      read_entry                 = cur;
      read_entry.pending_event   = EV_NONE;
   end

   // Holding stage: a poll event waits here until it is known whether a later
   // button of the same poll has an event too.
   logic    h_valid_ff;
   rsp_type h_rsp_ff;
   logic    h_open;
   logic    h_move;
   logic    o_free;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign h_open = h_valid_ff && !h_rsp_ff.last;

   always_comb begin
      res     = '0;
      has_res = 1'b0;
      if (s1_tok_ff.func == FUNC_READ) begin
         has_res       = 1'b1;
         res.button    = s1_tok_ff.button;
         res.event_res = s1_tok_ff.in_range ? cur.pending_event : EV_NONE;
         res.pressed   = s1_tok_ff.in_range && cur.debounced_level;
         res.last      = 1'b1;
      end else if (poll_ev != EV_NONE) begin
         has_res       = 1'b1;
         res.button    = s1_tok_ff.button;
         res.event_res = poll_ev;
         res.pressed   = deb_n;
         res.last      = s1_tok_ff.last;
      end else if (s1_tok_ff.last && !h_open) begin
         // Poll without any event: one empty result.
         has_res       = 1'b1;
         res.event_res = EV_NONE;
         res.last      = 1'b1;
      end
   end

   assign o_free   = !rsp_valid_ff || rsp_ready;
   assign s1_adv   = s1_valid_ff && (!has_res || !h_valid_ff || o_free);
   assign h_move   = h_valid_ff && o_free && (h_rsp_ff.last || (s1_adv && has_res));
   assign mem_we   = s1_adv && ((s1_tok_ff.func == FUNC_POLL) || s1_tok_ff.in_range);
   assign entry_in = (s1_tok_ff.func == FUNC_POLL) ? poll_entry : read_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (s1_adv && has_res) begin
         h_valid_ff <= 1'b1;
      end else if (h_move) begin
         h_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && has_res) begin
         h_rsp_ff <= res;
      end else if (s1_adv && s1_tok_ff.last && h_open) begin
         // Poll ended without further events: the held one is final.
         h_rsp_ff.last <= 1'b1;
      end
   end

   // ------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (h_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (h_move) begin
         rsp_data_ff <= h_rsp_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------ assertions
   `ASSERT_SAME(a_item_drained, clock, reset, req_take && item_valid_ff,
                issue && tok_last,
                "new item taken before the previous one was fully issued")
   `ASSERT_NEXT(a_stall_holds_token, clock, reset, s1_valid_ff && !s1_adv,
                s1_valid_ff && $stable(s1_tok_ff),
                "stalled update stage lost its token")
   `ASSERT_SAME(a_no_open_result, clock, reset, !item_valid_ff && !s1_valid_ff,
                !h_valid_ff || h_rsp_ff.last,
                "held result left without a last flag after its poll")
   `ASSERT_SAME(a_write_in_range, clock, reset, mem_we,
                {1'b0, s1_tok_ff.addr} < (BTN_AW + 1)'(NUM_BUTTONS),
                "state write beyond the button count")

endmodule
`default_nettype wire

// ----- verif/tb_button_debounce_hold_detector_unit.sv -----
// ----------------------------------------------------------------------------
// Button debounce and hold detector testbench
// Drives poll and read items through the request channel, keeps a cycle-free
// predictor of every button's debounce, press, hold and pending-event state,
// and checks each response transfer in order against the predicted results.
// ----------------------------------------------------------------------------
module tb_button_debounce_hold_detector_unit;
   import btn_dbnc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles to let pass after the last result before touching registers or
   // ending the run.
   localparam int SETTLE_CYCLES = 20;

   // Register indexes that map to no register; writes there must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = '1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_data = '0;

   // Predictor copy of the configuration and of each button's state.
   logic [15:0] debounce_lim_ms = DEBOUNCE_RESET;
   logic [15:0] hold_lim_ms     = HOLD_RESET;
   logic        raw_seen   [NUM_BUTTONS] = '{default: 1'b0};
   logic [31:0] change_at  [NUM_BUTTONS] = '{default: 32'd0};
   logic        deb_level  [NUM_BUTTONS] = '{default: 1'b0};
   logic [31:0] press_at   [NUM_BUTTONS] = '{default: 32'd0};
   logic        hold_fired [NUM_BUTTONS] = '{default: 1'b0};
   event_type   pend_ev    [NUM_BUTTONS] = '{default: EV_NONE};

   // Button results predicted but not yet seen on the response channel.
   rsp_type expected_results[$];

   int     mismatch_count = 0;
   int     polls_sent     = 0;
   int     reads_sent     = 0;
   int     results_seen   = 0;
   int     events_seen    = 0;
   int     rsp_hold_left  = 0;
   bit     calm_mode      = 1'b0;   // no idling on either side while set
   logic [31:0] sim_ms    = 32'd0;  // running millisecond stamp for polls
   rsp_type     want_rsp;

   button_debounce_hold_detector_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 0;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #2_000_000;
      $display("button_debounce_hold_detector_unit test failed");
      $finish;
   end

   // Gap length in cycles: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   // Work out the results one accepted item causes and advance the
   // predictor state. Events come out in ascending button order; the final
   // result of the item carries last.
   function automatic void predict_button_results(input req_type item);
      rsp_type     res;
      rsp_type     found[$];
      logic        raw;
      logic [31:0] elapsed;
      logic [31:0] hold_need;
      event_type   ev;
      int          b;

      res = '0;
      if (item.func == FUNC_READ) begin
         res.button = item.button_sel;
         res.last   = 1'b1;
         if (item.button_sel < NUM_BUTTONS) begin
            res.event_res = pend_ev[item.button_sel];
            res.pressed   = deb_level[item.button_sel];
            pend_ev[item.button_sel] = EV_NONE;
         end else begin
            // Out of range: nothing pressed, nothing pending, state untouched.
            res.event_res = EV_NONE;
            res.pressed   = 1'b0;
         end
         expected_results.push_back(res);
         return;
      end

      // A zero hold time counts as one, so a hold never fires on the poll
      // that accepted the press.
      hold_need = (hold_lim_ms == 16'd0) ? 32'd1 : {16'd0, hold_lim_ms};
      for (b = 0; b < NUM_BUTTONS; b++) begin
         raw = item.raw_levels[b];
         ev  = EV_NONE;
         if (raw != raw_seen[b]) begin
            raw_seen[b]  = raw;
            change_at[b] = item.now_ms;
         end
         elapsed = item.now_ms - change_at[b];
         if (elapsed >= {16'd0, debounce_lim_ms} && raw_seen[b] != deb_level[b]) begin
            deb_level[b] = raw_seen[b];
            if (deb_level[b]) begin
               ev            = EV_PRESSED;
               press_at[b]   = item.now_ms;
               hold_fired[b] = 1'b0;
            end else begin
               ev = EV_RELEASED;
            end
         end
         elapsed = item.now_ms - press_at[b];
         if (ev == EV_NONE && deb_level[b] && !hold_fired[b] && elapsed >= hold_need) begin
            ev            = EV_HELD;
            hold_fired[b] = 1'b1;
         end
         if (ev != EV_NONE) begin
            pend_ev[b]    = ev;
            res.button    = 3'(b);
            res.event_res = ev;
            res.pressed   = deb_level[b];
            res.last      = 1'b0;
            found.push_back(res);
         end
      end

      if (found.size() == 0) begin
         res = '0;
         res.event_res = EV_NONE;
         res.last      = 1'b1;
         expected_results.push_back(res);
      end else begin
         events_seen += found.size();
         foreach (found[k]) begin
            res      = found[k];
            res.last = (k == found.size() - 1);
            expected_results.push_back(res);
         end
      end
   endfunction

   // Offer one item after a random gap and hold it until the transfer.
   // Valid stays up when the next item follows with no gap.
   task automatic send_item(input req_type item);
      int gap;
      gap = calm_mode ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_button_results(item);
      if (item.func == FUNC_READ) reads_sent++;
      else polls_sent++;
   endtask

   task automatic send_poll(input logic [4:0] levels, input logic [31:0] stamp);
      req_type item;
      item.func       = FUNC_POLL;
      item.raw_levels = levels;
      item.now_ms     = stamp;
      item.button_sel = 3'($urandom);
      send_item(item);
   endtask

   // Unused fields of a read carry random bits.
   task automatic send_read(input logic [2:0] sel);
      req_type item;
      item.func       = FUNC_READ;
      item.raw_levels = 5'($urandom);
      item.now_ms     = $urandom;
      item.button_sel = sel;
      send_item(item);
   endtask

   // Drop valid, drain every outstanding result, then let the pipe settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only called with the block idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DEBOUNCE: debounce_lim_ms = value;
         CSR_HOLD:     hold_lim_ms     = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Response side stalls: stretches of ready, random holds in between.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm_mode && $urandom_range(0, 4) == 0) rsp_hold_left = pick_gap();
      end
   end

   // Compare every response transfer with the oldest predicted result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result btn %0d ev %0d pr %0b last %0b",
                                      rsp_data.button, rsp_data.event_res,
                                      rsp_data.pressed, rsp_data.last));
         end else begin
            want_rsp = expected_results.pop_front();
            if (rsp_data.button !== want_rsp.button)
               report_mismatch($sformatf("button got %0d want %0d",
                                         rsp_data.button, want_rsp.button));
            if (rsp_data.event_res !== want_rsp.event_res)
               report_mismatch($sformatf("event on button %0d got %0d want %0d",
                                         want_rsp.button, rsp_data.event_res,
                                         want_rsp.event_res));
            if (rsp_data.pressed !== want_rsp.pressed)
               report_mismatch($sformatf("pressed on button %0d got %0b want %0b",
                                         want_rsp.button, rsp_data.pressed,
                                         want_rsp.pressed));
            if (rsp_data.last !== want_rsp.last)
               report_mismatch($sformatf("last on button %0d got %0b want %0b",
                                         want_rsp.button, rsp_data.last, want_rsp.last));
         end
      end
   end

   // Reset settings: debounce of a press, pending event reads, hold,
   // release, a bouncing press, and reads past the last button.
   task automatic test_default_timing();
      send_poll(5'b00000, 32'd0);      // quiet poll gives the single none result
      send_poll(5'b11111, 32'd10);     // every button starts to settle
      send_poll(5'b11111, 32'd59);     // one ms short of the debounce time
      send_poll(5'b11111, 32'd60);     // all five accept the press
      send_read(3'd0);                 // fetch and clear the press event
      send_read(3'd0);                 // now nothing pending
      send_read(3'd5);
      send_read(3'd7);
      send_poll(5'b11111, 32'd559);
      send_poll(5'b11111, 32'd560);    // hold fires on every button
      send_poll(5'b11111, 32'd900);    // and only once
      send_poll(5'b00000, 32'd600 + 32'd400);
      send_poll(5'b00000, 32'd1050);   // release accepted
      send_poll(5'b00001, 32'd1100);   // contact bounce on button 0
      send_poll(5'b00000, 32'd1110);
      send_poll(5'b00001, 32'd1120);
      send_poll(5'b00001, 32'd1160);   // 40 ms stable, not yet
      send_poll(5'b00001, 32'd1170);   // press accepted
      send_read(3'd4);
      wait_idle();
   endtask

   // Zero debounce and zero hold: a change is taken at once, the hold
   // waits for a later poll.
   task automatic test_zero_times();
      write_reg(CSR_DEBOUNCE, 16'd0);
      write_reg(CSR_HOLD, 16'd0);
      send_poll(5'b00010, 32'd2000);
      send_poll(5'b00010, 32'd2000);
      send_poll(5'b00010, 32'd2001);
      send_read(3'd1);
      wait_idle();
   endtask

   // Largest register values, with time stamps wrapping past 2^32.
   task automatic test_extreme_times_wrap();
      logic [31:0] t0;
      logic [31:0] t1;
      t0 = 32'hFFFE_FFF0;
      t1 = 32'hFFFF_FFF8;
      write_reg(CSR_DEBOUNCE, 16'hFFFF);
      write_reg(CSR_HOLD, 16'hFFFF);
      send_poll(5'b00000, t0);
      send_poll(5'b00000, t0 + 32'd65535);
      send_poll(5'b10100, t1);
      send_poll(5'b10100, t1 + 32'd65534);
      send_poll(5'b10100, t1 + 32'd65535);
      send_poll(5'b10100, t1 + 32'd131069);
      send_poll(5'b10100, t1 + 32'd131070);
      send_read(3'd2);
      wait_idle();
      sim_ms = t1 + 32'd131070;
   endtask

   // Writes to indexes with no register behind them must change nothing.
   task automatic test_spare_index();
      write_reg(CSR_DEBOUNCE, 16'd3);
      write_reg(CSR_HOLD, 16'd7);
      write_reg(CSR_SPARE_LO, 16'($urandom));
      write_reg(CSR_SPARE_HI, 16'($urandom));
      send_poll(5'b01011, sim_ms + 32'd1);
      send_poll(5'b01011, sim_ms + 32'd4);
      send_poll(5'b01011, sim_ms + 32'd11);
      wait_idle();
      sim_ms = sim_ms + 32'd11;
   endtask

   // Random traffic: buttons held at a slowly changing level with
   // occasional bounce, steady small time steps with rare jumps, and reads
   // of any index mixed in.
   task automatic test_random_traffic(input int n_items, input logic [15:0] dbn,
                                      input logic [15:0] hld, input bit calm);
      logic [4:0] level_goal;
      logic [4:0] noise;
      int         r;
      level_goal = 5'($urandom);
      write_reg(CSR_DEBOUNCE, dbn);
      write_reg(CSR_HOLD, hld);
      calm_mode = calm;
      for (int k = 0; k < n_items; k++) begin
         if ($urandom_range(0, 4) == 0) begin
            send_read(3'($urandom_range(0, 7)));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 2) sim_ms = $urandom;
            else if (r < 7) sim_ms = sim_ms + $urandom_range(100, 70000);
            else sim_ms = sim_ms + $urandom_range(0, 12);
            for (int b = 0; b < NUM_BUTTONS; b++)
               if ($urandom_range(0, 7) == 0) level_goal[b] = ~level_goal[b];
            noise = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'd0;
            send_poll(level_goal ^ noise, sim_ms);
         end
      end
      wait_idle();
      calm_mode = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_timing();
      test_zero_times();
      test_extreme_times_wrap();
      test_spare_index();
      test_random_traffic(62, 16'd0, 16'd1, 1'b0);
      test_random_traffic(62, 16'($urandom_range(1, 20)), 16'($urandom_range(0, 80)), 1'b0);
      test_random_traffic(62, 16'($urandom_range(1, 20)), 16'($urandom_range(0, 80)), 1'b1);
      test_random_traffic(62, 16'd20, 16'd0, 1'b0);

      $display("covered %0d polls and %0d reads over several debounce/hold settings,",
               polls_sent, reads_sent);
      $display("checked %0d results carrying %0d button events", results_seen, events_seen);
      if (mismatch_count == 0) begin
         $display("button_debounce_hold_detector_unit test passed");
      end else begin
         $display("button_debounce_hold_detector_unit test failed");
      end
      $finish;
   end

endmodule

// ----- button_debounce_hold_detector_unit.f -----
+incdir+hdl
hdl/btn_dbnc_pkg.sv
hdl/button_debounce_hold_detector_unit.sv
verif/tb_button_debounce_hold_detector_unit.sv
